// ===== sv/cwc_pkg.sv =====
// Package for the copy window composer.
// Holds the per-dimension status codes shared by the RTL and the checker.
`default_nettype none

package cwc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISMATCH = 2'd2
  } cwc_status_t;

  localparam int unsigned STATUS_BITS = 2;

endpackage

`default_nettype wire

// ===== sv/cwc_if.sv =====
// Valid/ready channel interfaces for the copy window composer.
// cwc_item_if carries one dimension in, cwc_result_if one composed window out.
`default_nettype none

interface cwc_item_if #(
  parameter int unsigned EXTENT_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [EXTENT_BITS-1:0] in_extent;
  logic [EXTENT_BITS-1:0] mid_extent_first;
  logic [EXTENT_BITS-1:0] mid_extent_second;
  logic [EXTENT_BITS-1:0] out_extent;
  logic [EXTENT_BITS-1:0] in_offset;
  logic [EXTENT_BITS-1:0] mid_offset_first;
  logic [EXTENT_BITS-1:0] first_size;
  logic [EXTENT_BITS-1:0] mid_offset_second;
  logic [EXTENT_BITS-1:0] out_offset;
  logic [EXTENT_BITS-1:0] second_size;
  logic                   last_dim;

  modport source (
    output valid, in_extent, mid_extent_first, mid_extent_second, out_extent,
           in_offset, mid_offset_first, first_size, mid_offset_second,
           out_offset, second_size, last_dim,
    input  ready
  );
  modport sink (
    input  valid, in_extent, mid_extent_first, mid_extent_second, out_extent,
           in_offset, mid_offset_first, first_size, mid_offset_second,
           out_offset, second_size, last_dim,
    output ready
  );
endinterface

interface cwc_result_if #(
  parameter int unsigned EXTENT_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [EXTENT_BITS-1:0] comp_in_extent;
  logic [EXTENT_BITS-1:0] comp_out_extent;
  logic [EXTENT_BITS-1:0] comp_in_offset;
  logic [EXTENT_BITS-1:0] comp_out_offset;
  logic [EXTENT_BITS-1:0] comp_size;
  logic [1:0]             dim_status;
  logic [1:0]             overall_status;
  logic                   last_out;

  modport source (
    output valid, comp_in_extent, comp_out_extent, comp_in_offset,
           comp_out_offset, comp_size, dim_status, overall_status, last_out,
    input  ready
  );
  modport sink (
    input  valid, comp_in_extent, comp_out_extent, comp_in_offset,
           comp_out_offset, comp_size, dim_status, overall_status, last_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/copy_window_compose.sv =====
// A result passes through the input register, then the result register,
// before it is offered on the result channel.
// Throughput: one dimension per cycle while the receiver takes results; the
// input register refills whenever the result register moves on.
// The path between the two registers is one range-end add, a compare and
// an offset subtract-add. Synchronous active-high reset clears both valid
// flags and the sticky status back to ok.
// Depends on cwc_pkg and the channel interfaces in cwc_if.sv.
`default_nettype none

module copy_window_compose #(
  parameter int unsigned EXTENT_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  cwc_item_if.sink       item,
  cwc_result_if.source   result
);
  import cwc_pkg::*;

  localparam int unsigned W = EXTENT_BITS;

  // Input register
  logic         s1_valid;
  logic [W-1:0] s1_in_extent, s1_out_extent, s1_mid_first, s1_mid_second;
  logic [W-1:0] s1_in_offset, s1_mid_off_first, s1_first_size;
  logic [W-1:0] s1_mid_off_second, s1_out_offset, s1_second_size;
  logic         s1_last;

  // Result register
  logic         out_valid;
  logic [W-1:0] comp_in_extent, comp_out_extent, comp_in_offset;
  logic [W-1:0] comp_out_offset, comp_size;
  cwc_status_t  dim_status, overall_status;
  logic         last_out;

  cwc_status_t  worst_status;

  logic         load_out;
  logic         load_in;

  // Combinational composition of the window held in the input register
  logic [W:0]   end_first, end_second, end_min;
  logic [W-1:0] begin_max;
  logic         overlap;
  cwc_status_t  dim_status_next, overall_status_next;
  logic [W-1:0] comp_in_offset_next, comp_out_offset_next, comp_size_next;

  assign load_out   = s1_valid && (!out_valid || result.ready);
  assign load_in    = item.valid && item.ready;
  assign item.ready = !s1_valid || load_out;

  always_comb begin
    end_first  = {1'b0, s1_mid_off_first}  + {1'b0, s1_first_size};
    end_second = {1'b0, s1_mid_off_second} + {1'b0, s1_second_size};
    end_min    = (end_first <= end_second) ? end_first : end_second;
    begin_max  = (s1_mid_off_first > s1_mid_off_second) ? s1_mid_off_first
                                                        : s1_mid_off_second;
    overlap    = end_min > {1'b0, begin_max};

    comp_in_offset_next  = '0;
    comp_out_offset_next = '0;
    comp_size_next       = '0;
    if (s1_mid_first != s1_mid_second) begin
      dim_status_next = ST_MISMATCH;
    end else if (!overlap) begin
      dim_status_next = ST_EMPTY;
    end else begin
      dim_status_next      = ST_OK;
      comp_in_offset_next  = s1_in_offset + (begin_max - s1_mid_off_first);
      comp_out_offset_next = s1_out_offset + (begin_max - s1_mid_off_second);
      comp_size_next       = end_min[W-1:0] - begin_max;
    end

    overall_status_next = (worst_status > dim_status_next) ? worst_status
                                                           : dim_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      worst_status <= ST_OK;
    end else begin
      if (load_in) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid    <= 1'b1;
        // The final dimension closes the composition, so the sticky status
        // starts afresh for the next one.
        worst_status <= s1_last ? ST_OK : overall_status_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      s1_in_extent      <= item.in_extent;
      s1_out_extent     <= item.out_extent;
      s1_mid_first      <= item.mid_extent_first;
      s1_mid_second     <= item.mid_extent_second;
      s1_in_offset      <= item.in_offset;
      s1_mid_off_first  <= item.mid_offset_first;
      s1_first_size     <= item.first_size;
      s1_mid_off_second <= item.mid_offset_second;
      s1_out_offset     <= item.out_offset;
      s1_second_size    <= item.second_size;
      s1_last           <= item.last_dim;
    end
    if (load_out) begin
      comp_in_extent  <= s1_in_extent;
      comp_out_extent <= s1_out_extent;
      comp_in_offset  <= comp_in_offset_next;
      comp_out_offset <= comp_out_offset_next;
      comp_size       <= comp_size_next;
      dim_status      <= dim_status_next;
      overall_status  <= overall_status_next;
      last_out        <= s1_last;
    end
  end

  assign result.valid           = out_valid;
  assign result.comp_in_extent  = comp_in_extent;
  assign result.comp_out_extent = comp_out_extent;
  assign result.comp_in_offset  = comp_in_offset;
  assign result.comp_out_offset = comp_out_offset;
  assign result.comp_size       = comp_size;
  assign result.dim_status      = dim_status;
  assign result.overall_status  = overall_status;
  assign result.last_out        = last_out;

endmodule

`default_nettype wire

// ===== sv/cwc_checker.sv =====
// Port-level checker for the copy window composer, bound to copy_window_compose.
// Depends on cwc_pkg for the status codes.
`default_nettype none

module cwc_checker #(
  parameter int unsigned EXTENT_BITS = 32
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   result_valid,
  input wire logic                   result_ready,
  input wire logic [EXTENT_BITS-1:0] comp_in_offset,
  input wire logic [EXTENT_BITS-1:0] comp_out_offset,
  input wire logic [EXTENT_BITS-1:0] comp_size,
  input wire logic [1:0]             dim_status,
  input wire logic [1:0]             overall_status
);
  import cwc_pkg::*;

  // A result that is not taken stays on offer.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result withdrawn before its transfer");

  // The overall status never ranks below the status of its own dimension.
  a_overall_ranks: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> overall_status >= dim_status)
    else $error("overall status below dimension status");

  // A failed dimension carries an empty window.
  a_failed_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (dim_status != ST_OK) |->
      comp_size == '0 && comp_in_offset == '0 && comp_out_offset == '0)
    else $error("failed dimension carries a non-empty window");

  // An overlapping dimension always copies at least one element.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (dim_status == ST_OK) |-> comp_size != '0)
    else $error("overlapping dimension with zero size");

endmodule

bind copy_window_compose cwc_checker #(
  .EXTENT_BITS(EXTENT_BITS)
) u_cwc_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .comp_in_offset  (result.comp_in_offset),
  .comp_out_offset (result.comp_out_offset),
  .comp_size       (result.comp_size),
  .dim_status      (result.dim_status),
  .overall_status  (result.overall_status)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for copy_window_compose: directed and random dimensions,
// checked against a scoreboard that composes the two copy windows on its own.
// Depends on cwc_pkg and the channel interfaces in cwc_if.sv.

package cwc_tb_pkg;
  import cwc_pkg::*;

  localparam int unsigned EXT_W = 32;

  typedef struct packed {
    logic [EXT_W-1:0] in_extent;
    logic [EXT_W-1:0] mid_extent_first;
    logic [EXT_W-1:0] mid_extent_second;
    logic [EXT_W-1:0] out_extent;
    logic [EXT_W-1:0] in_offset;
    logic [EXT_W-1:0] mid_offset_first;
    logic [EXT_W-1:0] first_size;
    logic [EXT_W-1:0] mid_offset_second;
    logic [EXT_W-1:0] out_offset;
    logic [EXT_W-1:0] second_size;
    logic             last_dim;
  } dim_item_t;

  typedef struct packed {
    logic [EXT_W-1:0] comp_in_extent;
    logic [EXT_W-1:0] comp_out_extent;
    logic [EXT_W-1:0] comp_in_offset;
    logic [EXT_W-1:0] comp_out_offset;
    logic [EXT_W-1:0] comp_size;
    cwc_status_t      dim_status;
    cwc_status_t      overall_status;
    logic             last_out;
  } window_t;

  class window_scoreboard;
    cwc_status_t worst;
    window_t     expected_windows[$];
    int unsigned errors;

    function new();
      worst  = ST_OK;
      errors = 0;
    endfunction

    // Intersects the two middle ranges with a carry bit on each end, then maps
    // the overlap back to the source and forward to the destination.
    function window_t compose_window(dim_item_t it);
      window_t          w;
      logic [EXT_W:0]   end_first;
      logic [EXT_W:0]   end_second;
      logic [EXT_W:0]   end_min;
      logic [EXT_W-1:0] start;
      cwc_status_t      st;
      end_first  = {1'b0, it.mid_offset_first} + {1'b0, it.first_size};
      end_second = {1'b0, it.mid_offset_second} + {1'b0, it.second_size};
      end_min    = (end_first <= end_second) ? end_first : end_second;
      start      = (it.mid_offset_first > it.mid_offset_second) ?
                   it.mid_offset_first : it.mid_offset_second;
      w.comp_in_extent  = it.in_extent;
      w.comp_out_extent = it.out_extent;
      w.comp_in_offset  = '0;
      w.comp_out_offset = '0;
      w.comp_size       = '0;
      if (it.mid_extent_first != it.mid_extent_second) begin
        st = ST_MISMATCH;
      end else if (end_min <= {1'b0, start}) begin
        st = ST_EMPTY;
      end else begin
        st = ST_OK;
        w.comp_in_offset  = it.in_offset + (start - it.mid_offset_first);
        w.comp_out_offset = it.out_offset + (start - it.mid_offset_second);
        w.comp_size       = end_min[EXT_W-1:0] - start;
      end
      w.dim_status     = st;
      w.overall_status = (worst > st) ? worst : st;
      w.last_out       = it.last_dim;
      worst = it.last_dim ? ST_OK : w.overall_status;
      return w;
    endfunction

    function void note_item(dim_item_t it);
      expected_windows.insert(expected_windows.size(), compose_window(it));
    endfunction

    function void check_field(string name, logic [EXT_W-1:0] want, logic [EXT_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(window_t got);
      window_t want;
      if (expected_windows.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        return;
      end
      want = expected_windows.pop_front();
      check_field("comp_in_extent", want.comp_in_extent, got.comp_in_extent);
      check_field("comp_out_extent", want.comp_out_extent, got.comp_out_extent);
      check_field("comp_in_offset", want.comp_in_offset, got.comp_in_offset);
      check_field("comp_out_offset", want.comp_out_offset, got.comp_out_offset);
      check_field("comp_size", want.comp_size, got.comp_size);
      check_field("dim_status", EXT_W'(want.dim_status), EXT_W'(got.dim_status));
      check_field("overall_status", EXT_W'(want.overall_status),
                  EXT_W'(got.overall_status));
      check_field("last_out", EXT_W'(want.last_out), EXT_W'(got.last_out));
    endfunction

    function int unsigned pending();
      return expected_windows.size();
    endfunction
  endclass

endpackage

module tb_top;
  import cwc_pkg::*;
  import cwc_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;

  logic clk;
  logic rst;
  bit   idle_en;
  bit   hold_req;

  window_scoreboard sb;

  cwc_item_if   #(.EXTENT_BITS(EXT_W)) item_ch ();
  cwc_result_if #(.EXTENT_BITS(EXT_W)) result_ch ();

  copy_window_compose #(.EXTENT_BITS(EXT_W)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both sides are sampled at the same edge; the input is noted first so the
  // order of the two checks never depends on scheduling.
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      sb.note_item('{item_ch.in_extent, item_ch.mid_extent_first,
                     item_ch.mid_extent_second, item_ch.out_extent,
                     item_ch.in_offset, item_ch.mid_offset_first,
                     item_ch.first_size, item_ch.mid_offset_second,
                     item_ch.out_offset, item_ch.second_size, item_ch.last_dim});
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result('{result_ch.comp_in_extent, result_ch.comp_out_extent,
                        result_ch.comp_in_offset, result_ch.comp_out_offset,
                        result_ch.comp_size, cwc_status_t'(result_ch.dim_status),
                        cwc_status_t'(result_ch.overall_status), result_ch.last_out});
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random back-pressure, or one long hold-off when asked for.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_ch.ready <= !(idle_en && $urandom_range(99) < 37);
      end
    end
  end

  function automatic dim_item_t dim(
    logic [EXT_W-1:0] ie, logic [EXT_W-1:0] m1, logic [EXT_W-1:0] m2,
    logic [EXT_W-1:0] oe, logic [EXT_W-1:0] ox, logic [EXT_W-1:0] oy1,
    logic [EXT_W-1:0] s1, logic [EXT_W-1:0] oy2, logic [EXT_W-1:0] oz,
    logic [EXT_W-1:0] s2, logic is_last);
    return '{ie, m1, m2, oe, ox, oy1, s1, oy2, oz, s2, is_last};
  endfunction

  function automatic logic [EXT_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom_range(64);
      1:       return 32'hFFFF_FFFF - $urandom_range(64);
      default: return $urandom();
    endcase
  endfunction

  function automatic dim_item_t random_dim(logic is_last);
    dim_item_t        it;
    int unsigned      kind;
    logic [EXT_W-1:0] span;
    kind = $urandom_range(99);
    it.in_extent  = pick_value();
    it.out_extent = pick_value();
    it.in_offset  = pick_value();
    it.out_offset = pick_value();
    it.last_dim   = is_last;
    if (kind < 60) begin
      // Well-formed: both windows lie inside one shared middle extent.
      span = ($urandom_range(9) == 0) ? $urandom_range(32'h00FF_FFFF, 1) :
                                        $urandom_range(256, 1);
      it.mid_extent_first  = span;
      it.mid_extent_second = span;
      it.mid_offset_first  = $urandom_range(span - 1);
      it.first_size        = 1 + $urandom_range(span - it.mid_offset_first - 1);
      it.mid_offset_second = $urandom_range(span - 1);
      it.second_size       = 1 + $urandom_range(span - it.mid_offset_second - 1);
    end else if (kind < 75) begin
      // Ranges near the top of the index space, so the ends can carry out.
      it.mid_extent_first  = pick_value();
      it.mid_extent_second = it.mid_extent_first;
      it.mid_offset_first  = 32'hFFFF_FFFF - $urandom_range(1023);
      it.first_size        = $urandom_range(1) ? $urandom_range(2047) : $urandom();
      it.mid_offset_second = 32'hFFFF_FFFF - $urandom_range(1023);
      it.second_size       = $urandom_range(1) ? $urandom_range(2047) : $urandom();
    end else if (kind < 85) begin
      it.mid_extent_first  = $urandom();
      it.mid_extent_second = it.mid_extent_first ^ (32'h1 << $urandom_range(31));
      it.mid_offset_first  = $urandom_range(63);
      it.first_size        = $urandom_range(63);
      it.mid_offset_second = $urandom_range(63);
      it.second_size       = $urandom_range(63);
    end else begin
      it.mid_extent_first  = $urandom();
      it.mid_extent_second = $urandom_range(1) ? it.mid_extent_first : $urandom();
      it.mid_offset_first  = $urandom();
      it.first_size        = ($urandom_range(9) == 0) ? '0 : $urandom();
      it.mid_offset_second = $urandom();
      it.second_size       = ($urandom_range(9) == 0) ? '0 : $urandom();
    end
    return it;
  endfunction

  task automatic send_dim(input dim_item_t it);
    while (idle_en && $urandom_range(99) < 37) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid             <= 1'b1;
    item_ch.in_extent         <= it.in_extent;
    item_ch.mid_extent_first  <= it.mid_extent_first;
    item_ch.mid_extent_second <= it.mid_extent_second;
    item_ch.out_extent        <= it.out_extent;
    item_ch.in_offset         <= it.in_offset;
    item_ch.mid_offset_first  <= it.mid_offset_first;
    item_ch.first_size        <= it.first_size;
    item_ch.mid_offset_second <= it.mid_offset_second;
    item_ch.out_offset        <= it.out_offset;
    item_ch.second_size       <= it.second_size;
    item_ch.last_dim          <= it.last_dim;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Sends whole tensors; now and then a stray last flag breaks a sequence early.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned ndims;
    sent = 0;
    while (sent < count) begin
      ndims = $urandom_range(6, 1);
      for (int unsigned d = 0; d < ndims; d++) begin
        send_dim(random_dim(d == ndims - 1 || $urandom_range(19) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    sb       = new();
    idle_en  = 1'b1;
    hold_req = 1'b0;
    rst      <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.in_extent <= '0;
    item_ch.mid_extent_first <= '0;
    item_ch.mid_extent_second <= '0;
    item_ch.out_extent <= '0;
    item_ch.in_offset <= '0;
    item_ch.mid_offset_first <= '0;
    item_ch.first_size <= '0;
    item_ch.mid_offset_second <= '0;
    item_ch.out_offset <= '0;
    item_ch.second_size <= '0;
    item_ch.last_dim <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero sizes, then an overlap closing a tensor whose earlier dimension was empty.
    send_dim(dim(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_dim(dim(40, 100, 100, 60, 5, 10, 20, 15, 7, 30, 1));
    // Mismatch wins over an overlap, and stays sticky past an empty dimension.
    send_dim(dim(40, 100, 101, 60, 5, 10, 20, 15, 7, 30, 0));
    send_dim(dim(40, 100, 100, 60, 5, 0, 10, 10, 3, 5, 0));
    send_dim(dim(40, 100, 100, 60, 5, 10, 20, 15, 7, 30, 1));
    send_dim(dim(9, 50, 50, 9, 1, 20, 0, 20, 2, 10, 0));
    send_dim(dim(9, 50, 50, 9, 1, 20, 10, 25, 2, 0, 1));
    send_dim(dim('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1));
    // Both range ends carry; then only the first; then only the second.
    send_dim(dim(32'h8000_0000, '1, '1, 1, 32'h10, 32'hFFFF_FFF0, '1,
                 32'hFFFF_FFF8, 32'h20, 32'h20, 0));
    send_dim(dim(1, 7, 7, 2, '1, 32'hFFFF_FFF0, 32'h100, 32'hFFFF_FFF8,
                 32'hFFFF_FFFE, 4, 0));
    send_dim(dim(3, 3, 3, 3, 0, 100, 200, 32'hFFFF_FF00, 0, 32'h200, 0));
    send_dim(dim(1, 5, 6, 1, 0, 0, 1, 3, 0, 1, 1));
    send_dim(dim(10, 64, 64, 10, 32'h1234, 8, 40, 16, 32'h5678, 4, 1));
    send_dim(dim(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h1555_5555, 32'h4000_0000, 32'h2AAA_AAAA,
                 32'hD555_5555, 32'h2000_0000, 0));
    send_dim(dim(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFF, 32'h1555_5555,
                 32'h2AAA_AAAA, 32'h5FFF_FFFF, 1));

    run_random(600);
    idle_en = 1'b0;
    run_random(400);
    // Receiver holds off while the sender keeps offering, so the block fills up.
    hold_req = 1'b1;
    run_random(200);
    idle_en = 1'b1;
    run_random(500);
    item_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
